// ===== hw/rtl/dhpt_pkg.sv =====
// Shared constants, widths and operation codes of the double-hash page table.
package dhpt_pkg;

  localparam int PAGE_WORDS = 64;
  localparam int PAGE_COUNT = 64;
  localparam int MEM_WORDS  = PAGE_WORDS * PAGE_COUNT;

  localparam int OP_W   = 3;
  localparam int PID_W  = 32;
  localparam int OFF_W  = 16;
  localparam int DATA_W = 32;
  localparam int SLOT_W = $clog2(PAGE_COUNT);
  localparam int CNT_W  = $clog2(PAGE_COUNT + 1);
  localparam int ADDR_W = $clog2(MEM_WORDS);

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

endpackage

// ===== hw/rtl/dhpt_ifs.sv =====
// Request and response channel interfaces of the double-hash page table.
interface dhpt_req_if import dhpt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [PID_W-1:0]         pid;
  logic [OFF_W-1:0]         offset;
  logic signed [DATA_W-1:0] write_data;

  modport source (output valid, operation, pid, offset, write_data, input ready);
  modport sink   (input valid, operation, pid, offset, write_data, output ready);
endinterface

interface dhpt_rsp_if import dhpt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic [SLOT_W-1:0]        slot;
  logic signed [DATA_W-1:0] read_data;
  logic [OFF_W-1:0]         offset_echo;

  modport source (output valid, ok, slot, read_data, offset_echo, input ready);
  modport sink   (input valid, ok, slot, read_data, offset_echo, output ready);
endinterface

// ===== hw/rtl/dhpt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module dhpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/double_hash_page_table_unit.sv =====
// Process page table with open addressing and double hashing. One request at a
// time: an accepted transfer runs to completion before req.ready rises again,
// while a finished response may still wait in the output register. The probe
// sequence starts at slot pid[5:0] and steps by pid[11:6] forced odd; one slot
// of the sequence is examined per cycle through the slot RAMs, whose read
// address is the next probe index. Each request is accepted, then probes for
// its pid; a read then waits for the data RAM read, and the result is loaded
// into the response register. An insert that finds no match adds a free-page
// scan of one page per cycle and a second probe pass for an empty or tombstone
// slot. Requests with pid 0, unknown codes or, for write and read, an offset
// beyond the page skip the probe and answer with a failure. After reset the
// block clears all MEM_WORDS (4096) words of the data memory, one word per
// cycle, with req.ready low. Failing responses carry zero in slot, read_data
// and offset_echo.
module double_hash_page_table_unit import dhpt_pkg::*; (
  input logic        clk,
  input logic        rst,
  dhpt_req_if.sink   req,
  dhpt_rsp_if.source rsp
);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;  // data memory clearing pass
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FIND  = 3'd2;  // probe for the pid
  localparam logic [2:0] ST_FREE  = 3'd3;  // lowest free page scan
  localparam logic [2:0] ST_EMPTY = 3'd4;  // probe for empty or tombstone slot
  localparam logic [2:0] ST_RDW   = 3'd5;  // data RAM read latency
  localparam logic [2:0] ST_DONE  = 3'd6;  // hand result to output register

  logic [2:0]        state, state_next;

  // captured request
  logic [OP_W-1:0]   op;
  logic [PID_W-1:0]  pid;
  logic [OFF_W-1:0]  off;
  logic [DATA_W-1:0] wdata;

  // probe walker
  logic [SLOT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [SLOT_W-1:0] page, page_next;
  logic [SLOT_W-1:0] step;

  // table state kept in flops
  logic [PAGE_COUNT-1:0] ever_used;
  logic [PAGE_COUNT-1:0] page_busy;
  logic [CNT_W-1:0]      entry_count;
  logic [ADDR_W-1:0]     clr_cnt;

  // pending result
  logic              res_ok, res_ok_next;
  logic [SLOT_W-1:0] res_slot, res_slot_next;
  logic [DATA_W-1:0] res_rdata, res_rdata_next;
  logic [OFF_W-1:0]  res_echo, res_echo_next;

  // output register
  logic              out_valid;
  logic              out_ok;
  logic [SLOT_W-1:0] out_slot;
  logic [DATA_W-1:0] out_rdata;
  logic [OFF_W-1:0]  out_echo;

  // RAM ports
  logic              pid_we;
  logic [PID_W-1:0]  pid_wdata;
  logic [PID_W-1:0]  pid_rd;
  logic              page_we;
  logic [SLOT_W-1:0] page_rd;
  logic              data_we;
  logic [ADDR_W-1:0] mem_addr;
  logic              dram_we;
  logic [ADDR_W-1:0] dram_waddr;
  logic [DATA_W-1:0] dram_wdata;
  logic [DATA_W-1:0] data_rd;

  // table update strobes
  logic              ever_set;
  logic              busy_set;
  logic              busy_clr;
  logic [SLOT_W-1:0] busy_idx;
  logic              count_inc;
  logic              count_dec;

  logic req_fire;
  logic out_load;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  // second hash, forced odd so every slot is reachable
  assign step = pid[2*SLOT_W-1:SLOT_W] | SLOT_W'(1);

  // word address of the page held by the probed slot
  assign mem_addr = ADDR_W'(ADDR_W'(page_rd) * ADDR_W'(PAGE_WORDS)) + ADDR_W'(off);

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cnt_next       = cnt;
    page_next      = page;
    res_ok_next    = res_ok;
    res_slot_next  = res_slot;
    res_rdata_next = res_rdata;
    res_echo_next  = res_echo;
    pid_we         = 1'b0;
    pid_wdata      = '0;
    page_we        = 1'b0;
    data_we        = 1'b0;
    ever_set       = 1'b0;
    busy_set       = 1'b0;
    busy_clr       = 1'b0;
    busy_idx       = page;
    count_inc      = 1'b0;
    count_dec      = 1'b0;
    out_load       = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(MEM_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (req_fire) begin
          idx_next       = req.pid[SLOT_W-1:0];
          cnt_next       = '0;
          res_ok_next    = 1'b0;
          res_slot_next  = '0;
          res_rdata_next = '0;
          res_echo_next  = '0;
          // pid 0, unknown codes and out-of-page offsets fail at once
          if (req.pid == '0 ||
              (req.operation != OP_INSERT && req.operation != OP_SEARCH &&
               req.operation != OP_DELETE && req.operation != OP_WRITE &&
               req.operation != OP_READ) ||
              ((req.operation == OP_WRITE || req.operation == OP_READ) &&
               {1'b0, req.offset} >= (OFF_W + 1)'(PAGE_WORDS))) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_FIND;
          end
        end
      end

      ST_FIND: begin
        priority if (cnt == CNT_W'(PAGE_COUNT) || !ever_used[idx]) begin
          // not present
          if (op == OP_INSERT) begin
            state_next = ST_FREE;
            cnt_next   = '0;
          end else begin
            state_next = ST_DONE;
          end
        end else if (pid_rd == pid) begin
          res_slot_next = idx;
          res_ok_next   = (op != OP_INSERT);
          state_next    = ST_DONE;
          if (op == OP_INSERT) begin
            res_slot_next = '0;
          end else if (op == OP_DELETE) begin
            pid_we    = 1'b1;
            pid_wdata = '0;
            busy_clr  = 1'b1;
            busy_idx  = page_rd;
            count_dec = (entry_count != '0);
          end else if (op == OP_WRITE) begin
            data_we = 1'b1;
          end else if (op == OP_READ) begin
            res_echo_next = off;
            state_next    = ST_RDW;
          end
        end else begin
          idx_next = idx + step;
          cnt_next = cnt + CNT_W'(1);
        end
      end

      ST_FREE: begin
        priority if (cnt == CNT_W'(PAGE_COUNT)) begin
          state_next = ST_DONE;
        end else if (!page_busy[cnt[SLOT_W-1:0]]) begin
          page_next  = cnt[SLOT_W-1:0];
          idx_next   = pid[SLOT_W-1:0];
          cnt_next   = '0;
          state_next = ST_EMPTY;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end

      ST_EMPTY: begin
        priority if (cnt == CNT_W'(PAGE_COUNT)) begin
          state_next = ST_DONE;
        end else if (!ever_used[idx] || pid_rd == '0) begin
          state_next = ST_DONE;
          if (entry_count < CNT_W'(PAGE_COUNT)) begin
            pid_we        = 1'b1;
            pid_wdata     = pid;
            page_we       = 1'b1;
            ever_set      = 1'b1;
            busy_set      = 1'b1;
            busy_idx      = page;
            count_inc     = 1'b1;
            res_ok_next   = 1'b1;
            res_slot_next = idx;
          end
        end else begin
          idx_next = idx + step;
          cnt_next = cnt + CNT_W'(1);
        end
      end

      ST_RDW: begin
        res_rdata_next = data_rd;
        state_next     = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_cnt     <= '0;
      ever_used   <= '0;
      page_busy   <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
      if (ever_set) begin
        ever_used[idx] <= 1'b1;
      end
      if (busy_set) begin
        page_busy[busy_idx] <= 1'b1;
      end else if (busy_clr) begin
        page_busy[busy_idx] <= 1'b0;
      end
      if (count_inc) begin
        entry_count <= entry_count + CNT_W'(1);
      end else if (count_dec) begin
        entry_count <= entry_count - CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op    <= req.operation;
      pid   <= req.pid;
      off   <= req.offset;
      wdata <= req.write_data;
    end
    idx       <= idx_next;
    cnt       <= cnt_next;
    page      <= page_next;
    res_ok    <= res_ok_next;
    res_slot  <= res_slot_next;
    res_rdata <= res_rdata_next;
    res_echo  <= res_echo_next;
    if (out_load) begin
      out_ok    <= res_ok;
      out_slot  <= res_slot;
      out_rdata <= res_rdata;
      out_echo  <= res_echo;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.ok          = out_ok;
  assign rsp.slot        = out_slot;
  assign rsp.read_data   = out_rdata;
  assign rsp.offset_echo = out_echo;

  // slot RAMs read at idx_next so the entry for idx is on hand each cycle
  dhpt_ram #(.WIDTH(PID_W), .DEPTH(PAGE_COUNT)) u_pid_ram (
    .clk   (clk),
    .we    (pid_we),
    .waddr (idx),
    .wdata (pid_wdata),
    .raddr (idx_next),
    .rdata (pid_rd)
  );

  dhpt_ram #(.WIDTH(SLOT_W), .DEPTH(PAGE_COUNT)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (idx),
    .wdata (page),
    .raddr (idx_next),
    .rdata (page_rd)
  );

  // data words; the clearing pass owns the write port after reset
  assign dram_we    = (state == ST_CLEAR) || data_we;
  assign dram_waddr = (state == ST_CLEAR) ? clr_cnt : mem_addr;
  assign dram_wdata = (state == ST_CLEAR) ? '0 : wdata;

  dhpt_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_data_ram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (dram_waddr),
    .wdata (dram_wdata),
    .raddr (mem_addr),
    .rdata (data_rd)
  );

endmodule

// ===== hw/rtl/dhpt_checker.sv =====
// Port-level checker for the page table unit, bound into double_hash_page_table_unit.
module dhpt_checker import dhpt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_ok,
  input logic [SLOT_W-1:0] rsp_slot,
  input logic [DATA_W-1:0] rsp_read_data,
  input logic [OFF_W-1:0]  rsp_offset_echo
);

  // clearing pass follows reset: nothing taken, nothing answered
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("activity right after reset");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high after an accepted transfer");

  // failed requests carry zero payload
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_slot == '0 && rsp_read_data == '0 &&
                              rsp_offset_echo == '0)
    else $error("failed response with nonzero payload");

  // echoed offset lies inside a page
  a_echo_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> {1'b0, rsp_offset_echo} < (OFF_W + 1)'(PAGE_WORDS))
    else $error("offset echo outside the page");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
                                $stable(rsp_slot) && $stable(rsp_read_data) &&
                                $stable(rsp_offset_echo))
    else $error("response changed while stalled");

endmodule

bind double_hash_page_table_unit dhpt_checker u_dhpt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_ok          (rsp.ok),
  .rsp_slot        (rsp.slot),
  .rsp_read_data   (rsp.read_data),
  .rsp_offset_echo (rsp.offset_echo)
);

// ===== tb/testbench.sv =====
// Self-checking testbench of the double-hash page table: shadow table, random traffic, scoreboard.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dhpt_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int QUIET_ITEMS   = 150;   // tail of the run with no idling on either side
  localparam int SEGMENT_ITEMS = 120;   // length of one traffic mix
  localparam int POOL_SIZE     = 96;    // more ids than slots, so the table fills up
  localparam int SETTLE_CYCLES = 300;   // longer than the slowest insert
  // Bound: the slowest insert plus worst gaps and stalls on ~1225 transfers,
  // plus the memory clear after reset, taken several times over.
  localparam int CYCLE_LIMIT   = 1_000_000;

  // Operation codes the block does not implement.
  localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RESERVED_C = 3'd7;

  localparam logic [PID_W-1:0] PID_NONE = '0;
  localparam logic [PID_W-1:0] PID_ALL  = '1;
  // Both land on slot 1; the second steps by 3 and so ends up in slot 4.
  localparam logic [PID_W-1:0] PID_A    = 32'h0000_0041;
  localparam logic [PID_W-1:0] PID_B    = 32'h0000_0081;

  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic [OP_W-1:0]          operation;
    logic [PID_W-1:0]         pid;
    logic [OFF_W-1:0]         offset;
    logic signed [DATA_W-1:0] write_data;
  } page_req_t;

  typedef struct {
    logic                     ok;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] read_data;
    logic [OFF_W-1:0]         offset_echo;
  } page_rsp_t;

  // Shadow copy of the page table; predicts each response as its request is accepted.
  class page_table_shadow;
    logic [PID_W-1:0]  slot_pid   [PAGE_COUNT];
    logic [SLOT_W-1:0] slot_page  [PAGE_COUNT];
    bit                slot_used  [PAGE_COUNT];
    bit                page_busy  [PAGE_COUNT];
    int                entries;
    logic [DATA_W-1:0] data_words [MEM_WORDS];
    page_rsp_t         expected_rsps [$];
    int                errors;

    function new();
      for (int i = 0; i < PAGE_COUNT; i++) begin
        slot_pid[i]  = '0;
        slot_page[i] = '0;
        slot_used[i] = 1'b0;
        page_busy[i] = 1'b0;
      end
      for (int i = 0; i < MEM_WORDS; i++) data_words[i] = '0;
      entries = 0;
      errors  = 0;
    endfunction

    // Secondary hash, forced odd so the walk covers every slot.
    function int probe_step(logic [PID_W-1:0] pid);
      int s;
      s = int'((pid / 32'(PAGE_COUNT)) % 32'(PAGE_COUNT));
      if (s % 2 == 0) s++;
      return s;
    endfunction

    // Slot holding pid, or -1. Stops at a slot that was never used.
    function int lookup_slot(logic [PID_W-1:0] pid);
      int idx;
      int s;
      if (pid == PID_NONE) return -1;
      idx = int'(pid % 32'(PAGE_COUNT));
      s   = probe_step(pid);
      for (int i = 0; i < PAGE_COUNT && slot_used[idx]; i++) begin
        if (slot_pid[idx] == pid) return idx;
        idx = (idx + s) % PAGE_COUNT;
      end
      return -1;
    endfunction

    // First empty or tombstone slot on the probe walk, or -1.
    function int vacant_slot(logic [PID_W-1:0] pid);
      int idx;
      int s;
      idx = int'(pid % 32'(PAGE_COUNT));
      s   = probe_step(pid);
      for (int i = 0; i < PAGE_COUNT; i++) begin
        if (slot_pid[idx] == PID_NONE) return idx;
        idx = (idx + s) % PAGE_COUNT;
      end
      return -1;
    endfunction

    function int lowest_free_page();
      for (int i = 0; i < PAGE_COUNT; i++)
        if (!page_busy[i]) return i;
      return -1;
    endfunction

    function void apply_request(page_req_t r);
      page_rsp_t e;
      int        idx;
      int        page;
      int        addr;
      e.ok          = 1'b0;
      e.slot        = '0;
      e.read_data   = '0;
      e.offset_echo = '0;
      case (r.operation)
        OP_INSERT: begin
          if (r.pid != PID_NONE && lookup_slot(r.pid) < 0) begin
            page = lowest_free_page();
            idx  = vacant_slot(r.pid);
            if (page >= 0 && idx >= 0 && entries < PAGE_COUNT) begin
              slot_pid[idx]   = r.pid;
              slot_page[idx]  = SLOT_W'(page);
              slot_used[idx]  = 1'b1;
              page_busy[page] = 1'b1;
              entries++;
              e.ok   = 1'b1;
              e.slot = SLOT_W'(idx);
            end
          end
        end
        OP_SEARCH: begin
          idx = lookup_slot(r.pid);
          if (idx >= 0) begin
            e.ok   = 1'b1;
            e.slot = SLOT_W'(idx);
          end
        end
        OP_DELETE: begin
          idx = lookup_slot(r.pid);
          if (idx >= 0) begin
            page_busy[slot_page[idx]] = 1'b0;
            slot_pid[idx] = PID_NONE;   // tombstone: slot_used stays set
            if (entries > 0) entries--;
            e.ok   = 1'b1;
            e.slot = SLOT_W'(idx);
          end
        end
        OP_WRITE, OP_READ: begin
          idx = lookup_slot(r.pid);
          if (idx >= 0 && r.offset < PAGE_WORDS) begin
            addr = int'(slot_page[idx]) * PAGE_WORDS + int'(r.offset);
            if (r.operation == OP_WRITE) begin
              data_words[addr] = r.write_data;
            end else begin
              e.read_data   = data_words[addr];
              e.offset_echo = r.offset;
            end
            e.ok   = 1'b1;
            e.slot = SLOT_W'(idx);
          end
        end
        default: ;
      endcase
      expected_rsps = {expected_rsps, e};
    endfunction

    function void check_response(page_rsp_t got);
      page_rsp_t e;
      if (expected_rsps.size() == 0) begin
        $error("response transfer with no request outstanding");
        errors++;
        return;
      end
      e = expected_rsps.pop_front();
      if (got.ok !== e.ok) begin
        $error("ok: expected %0d, actual %0d", e.ok, got.ok);
        errors++;
      end
      if (got.slot !== e.slot) begin
        $error("slot: expected %0d, actual %0d", e.slot, got.slot);
        errors++;
      end
      if (got.read_data !== e.read_data) begin
        $error("read_data: expected %h, actual %h", e.read_data, got.read_data);
        errors++;
      end
      if (got.offset_echo !== e.offset_echo) begin
        $error("offset_echo: expected %h, actual %h", e.offset_echo, got.offset_echo);
        errors++;
      end
    endfunction

    // Random id currently in the table, or zero when it is empty.
    function logic [PID_W-1:0] resident_pid();
      logic [PID_W-1:0] held [$];
      for (int i = 0; i < PAGE_COUNT; i++)
        if (slot_pid[i] != PID_NONE) held = {held, slot_pid[i]};
      if (held.size() == 0) return PID_NONE;
      return held[$urandom_range(0, held.size() - 1)];
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  dhpt_req_if req_ch ();
  dhpt_rsp_if rsp_ch ();

  double_hash_page_table_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  page_table_shadow shadow;
  logic [PID_W-1:0] pid_pool [POOL_SIZE];
  bit               quiet;      // set for the tail of the run: no idling at all
  int               stall_left;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  // Response side: ready drops in random bursts, changes only at the falling edge.
  initial begin
    rsp_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready = 1'b1;
        if (!quiet && $urandom_range(0, 99) < 12) stall_left = $urandom_range(1, 11);
      end
    end
  end

  // Monitor: both channels sampled at the rising edge in one process. The response
  // is checked before the request is noted; a request never answers in its own cycle.
  always @(posedge clk) begin
    page_rsp_t got;
    page_req_t acc;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.ok          = rsp_ch.ok;
        got.slot        = rsp_ch.slot;
        got.read_data   = rsp_ch.read_data;
        got.offset_echo = rsp_ch.offset_echo;
        shadow.check_response(got);
      end
      if (req_ch.valid && req_ch.ready) begin
        acc.operation  = req_ch.operation;
        acc.pid        = req_ch.pid;
        acc.offset     = req_ch.offset;
        acc.write_data = req_ch.write_data;
        shadow.apply_request(acc);
      end
    end
  end

  // Present one request from the next falling edge until its transfer.
  task automatic send_request(page_req_t r);
    @(negedge clk);
    req_ch.valid      = 1'b1;
    req_ch.operation  = r.operation;
    req_ch.pid        = r.pid;
    req_ch.offset     = r.offset;
    req_ch.write_data = r.write_data;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [PID_W-1:0] pid,
                         logic [OFF_W-1:0] off, logic signed [DATA_W-1:0] wd);
    page_req_t r;
    r.operation  = op;
    r.pid        = pid;
    r.offset     = off;
    r.write_data = wd;
    send_request(r);
  endtask

  task automatic idle_requests(int cycles);
    @(negedge clk);
    req_ch.valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Hold off the sender until every outstanding response has been seen.
  task automatic wait_all_answered();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // One random request. mix 0 fills the table, 1 is balanced, 2 drains it.
  function automatic page_req_t make_random_request(int mix);
    page_req_t r;
    int        roll;
    int        ins, srch, del, wr, rd;
    case (mix)
      0:       begin ins = 55; srch = 63; del = 68; wr = 83; rd = 98; end
      1:       begin ins = 30; srch = 45; del = 63; wr = 80; rd = 97; end
      default: begin ins = 12; srch = 27; del = 67; wr = 82; rd = 98; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins)       r.operation = OP_INSERT;
    else if (roll < srch) r.operation = OP_SEARCH;
    else if (roll < del)  r.operation = OP_DELETE;
    else if (roll < wr)   r.operation = OP_WRITE;
    else if (roll < rd)   r.operation = OP_READ;
    else begin
      case ($urandom_range(0, 2))
        0:       r.operation = OP_RESERVED_A;
        1:       r.operation = OP_RESERVED_B;
        default: r.operation = OP_RESERVED_C;
      endcase
    end

    // Word accesses mostly target live ids so they get past the lookup.
    roll = $urandom_range(0, 99);
    r.pid = PID_NONE;
    if ((r.operation == OP_WRITE || r.operation == OP_READ) && roll < 75)
      r.pid = shadow.resident_pid();
    if (r.pid == PID_NONE) begin
      if (roll < 4)       r.pid = PID_NONE;
      else if (roll < 10) r.pid = $urandom;
      else                r.pid = pid_pool[$urandom_range(0, POOL_SIZE - 1)];
    end

    roll = $urandom_range(0, 99);
    if (roll < 80)      r.offset = OFF_W'($urandom_range(0, PAGE_WORDS - 1));
    else if (roll < 88) r.offset = OFF_W'($urandom_range(PAGE_WORDS, 65535));
    else if (roll < 94) r.offset = OFF_W'($urandom_range(PAGE_WORDS - 1, PAGE_WORDS));
    else                r.offset = OFF_W'($urandom);

    roll = $urandom_range(0, 99);
    if (roll < 90)      r.write_data = $urandom;
    else if (roll < 93) r.write_data = WORD_MIN;
    else if (roll < 96) r.write_data = WORD_MAX;
    else if (roll < 98) r.write_data = '1;
    else                r.write_data = '0;
    return r;
  endfunction

  initial begin
    logic [PID_W-1:0] v;
    shadow            = new();
    quiet             = 1'b0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.operation  = OP_INSERT;
    req_ch.pid        = '0;
    req_ch.offset     = '0;
    req_ch.write_data = '0;

    // Id pool: half share four home slots to force long probe walks.
    for (int i = 0; i < POOL_SIZE; i++) begin
      v = $urandom;
      if (i < POOL_SIZE / 2) v[SLOT_W-1:0] = SLOT_W'((i % 4) * 17);
      if (v == PID_NONE) v = 32'h1;
      pid_pool[i] = v;
    end
    pid_pool[0] = PID_ALL;
    pid_pool[1] = 32'h1;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Memory clear after reset is covered by the ready handshake.
    send_op(OP_INSERT, PID_NONE, '0, '0);        // id zero is never stored
    send_op(OP_SEARCH, PID_A, '0, '0);           // absent
    send_op(OP_INSERT, PID_A, '0, '0);           // slot 1, page 0
    send_op(OP_INSERT, PID_A, '0, '0);           // duplicate
    send_op(OP_INSERT, PID_B, '0, '0);           // collides, probes to slot 4
    send_op(OP_SEARCH, PID_B, '0, '0);
    send_op(OP_WRITE, PID_A, '0, WORD_MIN);
    send_op(OP_WRITE, PID_A, OFF_W'(PAGE_WORDS - 1), WORD_MAX);
    send_op(OP_READ, PID_A, '0, '0);
    send_op(OP_READ, PID_A, OFF_W'(PAGE_WORDS - 1), '0);
    send_op(OP_WRITE, PID_A, OFF_W'(PAGE_WORDS), '1);  // just past the page
    send_op(OP_READ, PID_A, '1, '0);                   // far past the page
    send_op(OP_READ, PID_B, '0, '0);                   // cleared memory
    send_op(OP_RESERVED_A, PID_A, '0, '0);
    send_op(OP_RESERVED_B, PID_B, '0, '0);
    send_op(OP_RESERVED_C, PID_ALL, '1, '1);
    send_op(OP_DELETE, PID_A, '0, '0);                 // tombstone in slot 1
    send_op(OP_SEARCH, PID_B, '0, '0);                 // walks past the tombstone
    send_op(OP_READ, PID_A, '0, '0);                   // deleted id
    send_op(OP_DELETE, PID_A, '0, '0);
    send_op(OP_INSERT, PID_ALL, '0, '0);               // reuses page 0
    send_op(OP_READ, PID_ALL, '0, '0);                 // old word still in page 0
    send_op(OP_SEARCH, PID_NONE, '0, '0);
    send_op(OP_DELETE, PID_NONE, '0, '0);
    send_op(OP_WRITE, PID_NONE, '0, WORD_MAX);

    wait_all_answered();

    // Random part: fill, balanced and drain mixes in turn, with a full drain
    // of outstanding responses every 400 requests.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 400 == 399) wait_all_answered();
      quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);
      if (!quiet && $urandom_range(0, 99) < 15) idle_requests($urandom_range(1, 11));
      send_request(make_random_request((n / SEGMENT_ITEMS) % 3));
    end

    wait_all_answered();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (shadow.pending() != 0) begin
      $error("%0d expected responses never arrived", shadow.pending());
      shadow.errors++;
    end
    if (shadow.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dhpt_pkg.sv
hw/rtl/dhpt_ifs.sv
hw/rtl/dhpt_ram.sv
hw/rtl/double_hash_page_table_unit.sv
hw/rtl/dhpt_checker.sv
tb/testbench.sv
